@@ rtl/core/hrav_pkg.sv @@
// ----------------------------------------------------------------------------
// hrav_pkg
// Shared widths, constants and types of the Hall tachometer speed averager.
// ----------------------------------------------------------------------------
package hrav_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES       = 2'd3;
  localparam int CFG_DATA_W = 20;

  localparam int INTERVAL_CFG_W = 20;
  localparam int SPEED_W        = 16;
  localparam int PPR_W          = 8;
  localparam int TS_W           = 32;

  localparam logic [INTERVAL_CFG_W-1:0] MIN_INTERVAL_RST = 20'd10000;
  localparam logic [SPEED_W-1:0]        MAX_SPEED_RST    = 16'd5000;
  localparam logic [SPEED_W-1:0]        MIN_SPEED_RST    = 16'd50;
  localparam logic [PPR_W-1:0]          PULSES_RST       = 8'd1;

  localparam int AVG_DEPTH_DEF = 4;
  localparam int QUEUE_DEPTH   = 2;

  // shared restoring divider: 26-bit dividend covers one minute in us
  localparam int DIV_NUM_W = 26;
  localparam int DIV_DEN_W = 32;
  localparam logic [DIV_NUM_W-1:0] TICKS_PER_MINUTE = 26'd60000000;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

endpackage

@@ rtl/core/hrav_if.sv @@
// ----------------------------------------------------------------------------
// hrav_in_if / hrav_out_if
// Valid/ready channels for Hall polls and averaged speed results.
// ----------------------------------------------------------------------------
interface hrav_in_if;
  logic                        valid;
  logic                        ready;
  logic                        hall_level;
  logic [hrav_pkg::TS_W-1:0]   timestamp_us;

  modport source (output valid, output hall_level, output timestamp_us, input ready);
  modport sink   (input valid, input hall_level, input timestamp_us, output ready);
endinterface

interface hrav_out_if;
  logic                          valid;
  logic                          ready;
  logic [hrav_pkg::SPEED_W-1:0]  speed_rpm;

  modport source (output valid, output speed_rpm, input ready);
  modport sink   (input valid, input speed_rpm, output ready);
endinterface

@@ rtl/core/hrav_fifo.sv @@
// ----------------------------------------------------------------------------
// hrav_fifo
// Short register queue of measured edge intervals between front and back.
// ----------------------------------------------------------------------------
module hrav_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  logic [hrav_pkg::TS_W-1:0] push_data,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output logic [hrav_pkg::TS_W-1:0] pop_data
);

  localparam int DEPTH = hrav_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [hrav_pkg::TS_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]          count_r;
  logic                      do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ rtl/core/hrav_front.sv @@
// ----------------------------------------------------------------------------
// hrav_front
// Rising edge detection, first edge capture, interval and debounce check.
// ----------------------------------------------------------------------------
module hrav_front (
  input  logic                                clk,
  input  logic                                rst_n,
  hrav_in_if.sink                             in_ch,
  input  logic [hrav_pkg::INTERVAL_CFG_W-1:0] min_interval,
  output logic                                push_valid,
  input  logic                                push_ready,
  output logic [hrav_pkg::TS_W-1:0]           push_data
);

  logic                      prior_r;
  logic                      await_r;
  logic [hrav_pkg::TS_W-1:0] ref_r;
  logic                      rising, pass, accept;
  logic [hrav_pkg::TS_W-1:0] interval;

  // stall whenever the queue is full, edge or not, to keep poll order
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign rising      = in_ch.hall_level && !prior_r;
  assign interval    = in_ch.timestamp_us - ref_r;
  // zero interval is always bounce
  assign pass        = (interval != '0) &&
                       (interval >= hrav_pkg::TS_W'(min_interval));
  assign push_valid  = in_ch.valid && rising && !await_r && pass;
  assign push_data   = interval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= 1'b0;
      await_r <= 1'b1;
      ref_r   <= '0;
    end else if (accept) begin
      prior_r <= in_ch.hall_level;
      if (rising) begin
        if (await_r) begin
          ref_r   <= in_ch.timestamp_us;
          await_r <= 1'b0;
        end else if (pass) begin
          ref_r <= in_ch.timestamp_us;
        end
      end
    end
  end

endmodule

@@ rtl/core/hrav_div.sv @@
// ----------------------------------------------------------------------------
// hrav_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module hrav_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hrav_pkg::div_req_t             req,
  output logic                           busy,
  output logic [hrav_pkg::DIV_NUM_W-1:0] quotient
);

  localparam int NW    = hrav_pkg::DIV_NUM_W;
  localparam int DW    = hrav_pkg::DIV_DEN_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NW - 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DW-1:0]    rem_r, den_r;
  logic [NW-1:0]    quo_r;
  logic [DW:0]      trial;
  logic [DW+1:0]    diff;
  logic             ge;

  assign trial    = {rem_r, quo_r[NW-1]};
  assign diff     = {1'b0, trial} - {2'b00, den_r};
  assign ge       = !diff[DW+1];
  assign busy     = busy_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= LAST;
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      else             cnt_r  <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

@@ rtl/core/hrav_back.sv @@
// ----------------------------------------------------------------------------
// hrav_back
// Speed computation, limit check, averaging ring and result register.
// ----------------------------------------------------------------------------
module hrav_back #(
  parameter int AVG_DEPTH = hrav_pkg::AVG_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [hrav_pkg::TS_W-1:0]    pop_data,
  input  logic [hrav_pkg::SPEED_W-1:0] max_speed,
  input  logic [hrav_pkg::SPEED_W-1:0] min_speed,
  input  logic [hrav_pkg::PPR_W-1:0]   pulses,
  hrav_out_if.source                   out_ch
);

  localparam int SW     = hrav_pkg::SPEED_W;
  localparam int NW     = hrav_pkg::DIV_NUM_W;
  localparam int DW     = hrav_pkg::DIV_DEN_W;
  localparam int SUM_W  = SW + $clog2(AVG_DEPTH);
  localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int PPR_W_LOC = hrav_pkg::PPR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_PPR  = 3'd2;
  localparam logic [2:0] S_MEAN = 3'd3;

  logic [2:0]        state_r, state_nxt;
  logic [SW-1:0]     ring_r [AVG_DEPTH];
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r;
  logic [SW-1:0]     out_speed_r;

  hrav_pkg::div_req_t     req;
  logic                   div_busy;
  logic [NW-1:0]          div_quo;
  logic [PPR_W_LOC-1:0]   ppr_eff;
  logic                   in_range, out_free, load_out, commit;

  hrav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign ppr_eff   = (pulses == '0) ? PPR_W_LOC'(1) : pulses;
  assign in_range  = (div_quo <= NW'(max_speed)) && (div_quo >= NW'(min_speed));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign pop_ready = (state_r == S_IDLE);

  // unfilled ring entries are zero, so a running sum matches the filled-entry sum
  assign sum_nxt   = sum_r - SUM_W'(ring_r[slot_r]) + SUM_W'(div_quo[SW-1:0]);
  assign count_nxt = (count_r == CNT_W'(AVG_DEPTH)) ? count_r : count_r + 1'b1;
  assign commit    = (state_r == S_PPR) && !div_busy && in_range;
  assign load_out  = (state_r == S_MEAN) && !div_busy && out_free;

  always_comb begin
    state_nxt    = state_r;
    req.start    = 1'b0;
    req.dividend = hrav_pkg::TICKS_PER_MINUTE;
    req.divisor  = pop_data;
    unique case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          req.start = 1'b1;
          state_nxt = S_TICK;
        end
      end
      S_TICK: begin
        req.dividend = div_quo;
        req.divisor  = DW'(ppr_eff);
        if (!div_busy) begin
          req.start = 1'b1;
          state_nxt = S_PPR;
        end
      end
      S_PPR: begin
        req.dividend = NW'(sum_nxt);
        req.divisor  = DW'(count_nxt);
        if (!div_busy) begin
          req.start = in_range;
          state_nxt = in_range ? S_MEAN : S_IDLE;
        end
      end
      S_MEAN: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AVG_DEPTH; i++) ring_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        ring_r[slot_r] <= div_quo[SW-1:0];
        slot_r  <= (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_speed_r <= div_quo[SW-1:0];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.speed_rpm = out_speed_r;

endmodule

@@ rtl/core/hall_tachometer_rpm_average.sv @@
// ----------------------------------------------------------------------------
// hall_tachometer_rpm_average
// Hall sensor tachometer: edge interval to rpm, moving average of speeds.
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// in_ch    in   valid/ready   hall_level, timestamp_us
// out_ch   out  valid/ready   speed_rpm
// cfg_*    in   cfg_we        cfg_index, cfg_wdata
//
// Polls transfer one per cycle while the two-entry interval queue has room.
// Each queued interval that makes a result takes three passes of the shared
// 26-step divider (minute/interval, /pulses, sum/count); two when the speed
// is dropped. The back end pops the next interval only once back in idle.
// Synchronous active-low reset; no clearing pass. The back end stalls only in
// its last step when the result register is still held by out_ch.
// ----------------------------------------------------------------------------
module hall_tachometer_rpm_average #(
  parameter int AVG_DEPTH = hrav_pkg::AVG_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  hrav_in_if.sink                           in_ch,
  hrav_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [hrav_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hrav_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [hrav_pkg::INTERVAL_CFG_W-1:0] min_interval_r;
  logic [hrav_pkg::SPEED_W-1:0]        max_speed_r, min_speed_r;
  logic [hrav_pkg::PPR_W-1:0]          pulses_r;

  logic                      push_valid, push_ready, pop_valid, pop_ready;
  logic [hrav_pkg::TS_W-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= hrav_pkg::MIN_INTERVAL_RST;
      max_speed_r    <= hrav_pkg::MAX_SPEED_RST;
      min_speed_r    <= hrav_pkg::MIN_SPEED_RST;
      pulses_r       <= hrav_pkg::PULSES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hrav_pkg::CFG_MIN_INTERVAL: min_interval_r <= cfg_wdata;
        hrav_pkg::CFG_MAX_SPEED:    max_speed_r <= cfg_wdata[hrav_pkg::SPEED_W-1:0];
        hrav_pkg::CFG_MIN_SPEED:    min_speed_r <= cfg_wdata[hrav_pkg::SPEED_W-1:0];
        hrav_pkg::CFG_PULSES:       pulses_r    <= cfg_wdata[hrav_pkg::PPR_W-1:0];
        default: ;
      endcase
    end
  end

  hrav_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .min_interval (min_interval_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  hrav_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hrav_back #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .max_speed (max_speed_r),
    .min_speed (min_speed_r),
    .pulses    (pulses_r),
    .out_ch    (out_ch)
  );

endmodule
